[sv/axis_excursion_triggered_capture_defines.svh]
// assertion macros shared by the checker of the excursion capture block
// depends on nothing
`ifndef AXIS_EXCURSION_TRIGGERED_CAPTURE_DEFINES_SVH
`define AXIS_EXCURSION_TRIGGERED_CAPTURE_DEFINES_SVH

// same-cycle implication
`define AETC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AETC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/aetc_pkg.sv]
// shared types and constants of the axis excursion capture block
// depends on nothing
package aetc_pkg;

   localparam int AXIS_COUNT = 4;
   localparam int AXIS_WIDTH = 12;
   localparam int BYTE_WIDTH = 8;
   localparam int DUMP_BYTES = 64;
   localparam int DUMP_IDX_WIDTH = 6;
   localparam int AXIS_IDX_WIDTH = 2;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_UPPER_CAP = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LOWER_CAP = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DUMP_TAG  = 2'd2;

   localparam logic [AXIS_WIDTH-1:0] UPPER_CAP_RESET = 12'd3830;
   localparam logic [AXIS_WIDTH-1:0] LOWER_CAP_RESET = 12'd265;
   localparam logic [BYTE_WIDTH-1:0] DUMP_TAG_RESET  = 8'd0;

   typedef struct packed {
      logic                  excursion;
      logic                  in_band;
      logic [BYTE_WIDTH-1:0] sample;
   } lane_out_type;

   typedef struct packed {
      logic                      start;
      logic [AXIS_IDX_WIDTH-1:0] axis;
   } dump_ctl_type;

endpackage

[sv/aetc_ram.sv]
// generic single write port ram with registered read
// depends on nothing
module aetc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/aetc_lane.sv]
// one axis lane: offset, cap compare and sample byte
// depends on aetc_pkg
module aetc_lane (
   input  logic signed [aetc_pkg::AXIS_WIDTH-1:0] axis_in,
   input  logic        [aetc_pkg::AXIS_WIDTH-1:0] hi_limit,
   input  logic        [aetc_pkg::AXIS_WIDTH-1:0] lo_limit,
   output aetc_pkg::lane_out_type                 lane_out
);

   logic [aetc_pkg::AXIS_WIDTH-1:0] offs;

   // adding 2048 flips the sign bit
   assign offs = {~axis_in[aetc_pkg::AXIS_WIDTH-1], axis_in[aetc_pkg::AXIS_WIDTH-2:0]};

   always_comb begin
      lane_out.excursion = (offs >= hi_limit) || (offs <= lo_limit);
      lane_out.in_band   = (offs < hi_limit) && (offs > lo_limit);
      lane_out.sample    = offs[aetc_pkg::AXIS_WIDTH-1 -: aetc_pkg::BYTE_WIDTH];
   end

endmodule

[sv/aetc_dump.sv]
// dump sequencer: ram read stage and output register for the 64-byte dump
// depends on aetc_pkg
module aetc_dump #(
   parameter int CAPTURE_LENGTH = 62,
   parameter int ADDR_WIDTH = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  aetc_pkg::dump_ctl_type            ctl,
   input  logic [aetc_pkg::BYTE_WIDTH-1:0]   dump_tag,
   output logic                              rd_en,
   output logic [ADDR_WIDTH-1:0]             rd_addr,
   input  logic [aetc_pkg::BYTE_WIDTH-1:0]   rd_data,
   output logic                              busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [aetc_pkg::BYTE_WIDTH-1:0]   rsp_dump_byte,
   output logic                              rsp_dump_last
);

   localparam int KW = aetc_pkg::DUMP_IDX_WIDTH + 1;

   logic                                  busy_ff, busy_in;
   logic [KW-1:0]                         k_ff, k_in;
   logic [aetc_pkg::AXIS_IDX_WIDTH-1:0]   axis_ff, axis_in;
   logic                                  b_vld_ff, b_vld_in;
   logic [aetc_pkg::DUMP_IDX_WIDTH-1:0]   b_k_ff, b_k_in;
   logic                                  b_smp_ff, b_smp_in;
   logic                                  out_vld_ff, out_vld_in;
   logic [aetc_pkg::BYTE_WIDTH-1:0]       out_byte_ff, out_byte_in;
   logic                                  out_last_ff, out_last_in;
   logic                                  out_free, issue_go, in_smp, done;
   logic [aetc_pkg::BYTE_WIDTH-1:0]       b_byte;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign in_smp   = (k_ff >= KW'(2)) && (k_ff < KW'(CAPTURE_LENGTH + 2));
   assign issue_go = busy_ff && (k_ff < KW'(aetc_pkg::DUMP_BYTES)) && (!b_vld_ff || out_free);
   assign done     = busy_ff && (k_ff == KW'(aetc_pkg::DUMP_BYTES)) && (!b_vld_ff || out_free);

   assign rd_en   = issue_go && in_smp;
   assign rd_addr = ADDR_WIDTH'(k_ff - KW'(2));

   always_comb begin
      if (b_k_ff == '0) begin
         b_byte = dump_tag;
      end else if (b_k_ff == aetc_pkg::DUMP_IDX_WIDTH'(1)) begin
         b_byte = aetc_pkg::BYTE_WIDTH'(axis_ff);
      end else if (b_smp_ff) begin
         b_byte = rd_data;
      end else begin
         b_byte = '0;
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      k_in        = k_ff;
      axis_in     = axis_ff;
      b_vld_in    = b_vld_ff;
      b_k_in      = b_k_ff;
      b_smp_in    = b_smp_ff;
      out_vld_in  = out_vld_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (out_free) begin
         out_vld_in  = b_vld_ff;
         out_byte_in = b_byte;
         out_last_in = (b_k_ff == aetc_pkg::DUMP_IDX_WIDTH'(aetc_pkg::DUMP_BYTES - 1));
         b_vld_in    = 1'b0;
      end
      if (issue_go) begin
         b_vld_in = 1'b1;
         b_k_in   = k_ff[aetc_pkg::DUMP_IDX_WIDTH-1:0];
         b_smp_in = in_smp;
         k_in     = k_ff + KW'(1);
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (ctl.start) begin
         busy_in = 1'b1;
         k_in    = '0;
         axis_in = ctl.axis;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         b_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         k_ff       <= '0;
      end else begin
         busy_ff    <= busy_in;
         b_vld_ff   <= b_vld_in;
         out_vld_ff <= out_vld_in;
         k_ff       <= k_in;
      end
      axis_ff     <= axis_in;
      b_k_ff      <= b_k_in;
      b_smp_ff    <= b_smp_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign busy          = busy_ff;
   assign rsp_valid     = out_vld_ff;
   assign rsp_dump_byte = out_byte_ff;
   assign rsp_dump_last = out_last_ff;

endmodule

[sv/axis_excursion_triggered_capture.sv]
// top level of the axis excursion triggered capture block
// depends on aetc_pkg, aetc_lane, aetc_ram, aetc_dump
//
//   port group | direction | handshake          | carries
//   req_       | in        | req_valid/req_stall | left_x, left_y, right_x, right_y
//   rsp_       | out       | rsp_valid/rsp_stall | dump_byte, dump_last
//   csr_       | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one item per cycle while idle, armed or capturing and no dump is running (four lanes
// compare in parallel); a finished capture stalls req_ while the dump sequencer runs,
// and the dump drains through the ram read stage, one byte per cycle without rsp_stall
// reset is synchronous and clears phase, caps to their defaults and the dump sequencer
// csr_ready is always high; writes are meant for idle periods
module axis_excursion_triggered_capture #(
   parameter int CAPTURE_LENGTH = 62
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [aetc_pkg::AXIS_WIDTH-1:0]     req_left_x,
   input  logic signed [aetc_pkg::AXIS_WIDTH-1:0]     req_left_y,
   input  logic signed [aetc_pkg::AXIS_WIDTH-1:0]     req_right_x,
   input  logic signed [aetc_pkg::AXIS_WIDTH-1:0]     req_right_y,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic        [aetc_pkg::BYTE_WIDTH-1:0]     rsp_dump_byte,
   output logic                                       rsp_dump_last,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic        [aetc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic        [aetc_pkg::AXIS_WIDTH-1:0]     csr_data
);

   localparam int ADDR_WIDTH = (CAPTURE_LENGTH > 1) ? $clog2(CAPTURE_LENGTH) : 1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ARMED,
      PH_CAPTURE
   } phase_type;

   phase_type                             phase_ff, phase_in;
   logic [aetc_pkg::AXIS_IDX_WIDTH-1:0]   axis_ff, axis_in;
   logic [ADDR_WIDTH-1:0]                 count_ff, count_in;
   logic [aetc_pkg::AXIS_WIDTH-1:0]       upper_ff, lower_ff;
   logic [aetc_pkg::BYTE_WIDTH-1:0]       tag_ff;

   logic signed [aetc_pkg::AXIS_WIDTH-1:0] axis_val [aetc_pkg::AXIS_COUNT];
   aetc_pkg::lane_out_type                 lane_out [aetc_pkg::AXIS_COUNT];
   aetc_pkg::lane_out_type                 chosen;
   aetc_pkg::dump_ctl_type                 dump_ctl;

   logic                                  req_fire, any_exc, wr_en, dump_busy;
   logic [aetc_pkg::AXIS_IDX_WIDTH-1:0]   first_exc;
   logic                                  rd_en;
   logic [ADDR_WIDTH-1:0]                 rd_addr;
   logic [aetc_pkg::BYTE_WIDTH-1:0]       rd_data;

   assign axis_val[0] = req_left_x;
   assign axis_val[1] = req_left_y;
   assign axis_val[2] = req_right_x;
   assign axis_val[3] = req_right_y;

   for (genvar g = 0; g < aetc_pkg::AXIS_COUNT; g++) begin : g_lane
      aetc_lane u_lane (
         .axis_in  (axis_val[g]),
         .hi_limit (upper_ff),
         .lo_limit (lower_ff),
         .lane_out (lane_out[g])
      );
   end

   // merge: first lane with an excursion, and the watched lane
   always_comb begin
      any_exc   = 1'b0;
      first_exc = '0;
      for (int i = aetc_pkg::AXIS_COUNT - 1; i >= 0; i--) begin
         if (lane_out[i].excursion) begin
            any_exc   = 1'b1;
            first_exc = aetc_pkg::AXIS_IDX_WIDTH'(i);
         end
      end
   end

   assign chosen    = lane_out[axis_ff];
   assign req_stall = dump_busy;
   assign req_fire  = req_valid && !req_stall;
   assign wr_en     = req_fire && (phase_ff == PH_CAPTURE);
   assign csr_ready = 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      axis_in        = axis_ff;
      count_in       = count_ff;
      dump_ctl.start = 1'b0;
      dump_ctl.axis  = axis_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (any_exc) begin
                  phase_in = PH_ARMED;
                  axis_in  = first_exc;
               end
            end
            PH_ARMED: begin
               if (chosen.in_band) begin
                  phase_in = PH_CAPTURE;
                  count_in = '0;
               end
            end
            PH_CAPTURE: begin
               if (count_ff == ADDR_WIDTH'(CAPTURE_LENGTH - 1)) begin
                  phase_in       = PH_IDLE;
                  count_in       = '0;
                  dump_ctl.start = 1'b1;
               end else begin
                  count_in = count_ff + ADDR_WIDTH'(1);
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         axis_ff  <= '0;
         count_ff <= '0;
         upper_ff <= aetc_pkg::UPPER_CAP_RESET;
         lower_ff <= aetc_pkg::LOWER_CAP_RESET;
         tag_ff   <= aetc_pkg::DUMP_TAG_RESET;
      end else begin
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               aetc_pkg::REG_UPPER_CAP: upper_ff <= csr_data;
               aetc_pkg::REG_LOWER_CAP: lower_ff <= csr_data;
               aetc_pkg::REG_DUMP_TAG:  tag_ff   <= csr_data[aetc_pkg::BYTE_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   aetc_ram #(
      .WIDTH (aetc_pkg::BYTE_WIDTH),
      .DEPTH (CAPTURE_LENGTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff),
      .wr_data (chosen.sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   aetc_dump #(
      .CAPTURE_LENGTH (CAPTURE_LENGTH),
      .ADDR_WIDTH     (ADDR_WIDTH)
   ) u_dump (
      .clock         (clock),
      .reset         (reset),
      .ctl           (dump_ctl),
      .dump_tag      (tag_ff),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .busy          (dump_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_dump_byte (rsp_dump_byte),
      .rsp_dump_last (rsp_dump_last)
   );

endmodule

[sv/aetc_checker.sv]
// port-level checks of the excursion capture block, bound to the top level
// depends on axis_excursion_triggered_capture_defines.svh and aetc_pkg
`include "axis_excursion_triggered_capture_defines.svh"

module aetc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [aetc_pkg::BYTE_WIDTH-1:0]      rsp_dump_byte,
   input logic                                 rsp_dump_last
);

   // stalled result item holds
   `AETC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_dump_byte) && $stable(rsp_dump_last), "stalled dump byte changed")

   // input held off while a dump byte other than the closing one is valid
   `AETC_ASSERT_NOW(a_stall_in_dump, clock, reset, rsp_valid && !rsp_dump_last, req_stall, "input open during dump")

   // nothing follows the closing byte right away
   `AETC_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_dump_last && !rsp_stall, !rsp_valid, "byte right after end of dump")

endmodule

bind axis_excursion_triggered_capture aetc_checker u_aetc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_dump_byte (rsp_dump_byte),
   .rsp_dump_last (rsp_dump_last)
);
